[src/qem_pkg.sv]
// qem_pkg: shared types, constants and helper functions of the quadrature
// encoder monitor. No dependencies; used by every module under src/.

package qem_pkg;

    // Stream payload widths (tdata in whole bytes)
    localparam int IN_TDATA_W  = 96;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 144;

    // Configuration port widths
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Field widths
    localparam int TIME_W  = 32;
    localparam int ADC_W   = 10;
    localparam int CNT_W   = 32;
    localparam int MS_W    = 16;
    localparam int SEEN_W  = 8;
    localparam int DFLAG_W = 6;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DIFF_MODE   = 3'd0,
        REG_DIFF_THRESH = 3'd1,
        REG_INDEX_HOLD  = 3'd2,
        REG_SPEED_WIN   = 3'd3,
        REG_IDLE_TMO    = 3'd4
    } t_reg_index;

    // Reset values of the configuration registers
    localparam logic             RST_DIFF_MODE   = 1'b0;
    localparam logic [ADC_W-1:0] RST_DIFF_THRESH = 10'd100;
    localparam logic [MS_W-1:0]  RST_INDEX_HOLD  = 16'd500;
    localparam logic [MS_W-1:0]  RST_SPEED_WIN   = 16'd1000;
    localparam logic [MS_W-1:0]  RST_IDLE_TMO    = 16'd200;

    // Item kind carried in tuser
    typedef enum logic {
        OP_EDGE = 1'b0,
        OP_POLL = 1'b1
    } t_opcode;

    // Direction / step, two's complement
    typedef logic signed [1:0] t_dir;
    localparam t_dir DIR_ZERO = 2'sb00;
    localparam t_dir DIR_POS  = 2'sb01;
    localparam t_dir DIR_NEG  = 2'sb11;

    // Step decode, indexed by {prev A, prev B, cur A, cur B}
    localparam t_dir STEP_TABLE [0:15] = '{
        DIR_ZERO, DIR_NEG,  DIR_POS,  DIR_ZERO,
        DIR_POS,  DIR_ZERO, DIR_ZERO, DIR_NEG,
        DIR_NEG,  DIR_ZERO, DIR_ZERO, DIR_POS,
        DIR_ZERO, DIR_POS,  DIR_NEG,  DIR_ZERO
    };

    // Configuration register set
    typedef struct packed {
        logic             diff_mode;
        logic [ADC_W-1:0] diff_thresh;
        logic [MS_W-1:0]  index_hold;
        logic [MS_W-1:0]  speed_win;
        logic [MS_W-1:0]  idle_tmo;
    } t_cfg;

    // One input item, unpacked from the stream
    typedef struct packed {
        t_opcode           opcode;
        logic              level_a;
        logic              level_b;
        logic              level_r;
        logic [TIME_W-1:0] now_ms;
        logic [ADC_W-1:0]  a_plus;
        logic [ADC_W-1:0]  a_minus;
        logic [ADC_W-1:0]  b_plus;
        logic [ADC_W-1:0]  b_minus;
        logic [ADC_W-1:0]  r_plus;
        logic [ADC_W-1:0]  r_minus;
    } t_item;

    // One result item
    typedef struct packed {
        logic [CNT_W-1:0]   position;
        t_dir               direction;
        logic [CNT_W-1:0]   speed;
        logic [CNT_W-1:0]   error_count;
        logic               index_present;
        logic [CNT_W-1:0]   index_pulse_count;
        logic               in_index_cycle;
        logic               a_seen_high;
        logic               b_seen_high;
        logic [DFLAG_W-1:0] diff_flags;
    } t_result;

    // Differential check: bit0 set when plus-minus > th, bit1 when < -th
    function automatic logic [1:0] diff_check(
        input logic [ADC_W-1:0] plus,
        input logic [ADC_W-1:0] minus,
        input logic [ADC_W-1:0] th
    );
        logic signed [ADC_W+1:0] d;
        logic signed [ADC_W+1:0] t;
        d = $signed({2'b00, plus}) - $signed({2'b00, minus});
        t = $signed({2'b00, th});
        return {(d < -t), (d > t)};
    endfunction

endpackage

[src/qem_cfg_regs.sv]
// qem_cfg_regs: configuration register file of the encoder monitor.
// Depends on qem_pkg (register indexes, reset values, t_cfg).

module qem_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [qem_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [qem_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output qem_pkg::t_cfg                  o_cfg
);

    qem_pkg::t_cfg r_cfg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.diff_mode   <= qem_pkg::RST_DIFF_MODE;
            r_cfg.diff_thresh <= qem_pkg::RST_DIFF_THRESH;
            r_cfg.index_hold  <= qem_pkg::RST_INDEX_HOLD;
            r_cfg.speed_win   <= qem_pkg::RST_SPEED_WIN;
            r_cfg.idle_tmo    <= qem_pkg::RST_IDLE_TMO;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                qem_pkg::REG_DIFF_MODE:   r_cfg.diff_mode   <= i_cfg_data[0];
                qem_pkg::REG_DIFF_THRESH: r_cfg.diff_thresh <= i_cfg_data[qem_pkg::ADC_W-1:0];
                qem_pkg::REG_INDEX_HOLD:  r_cfg.index_hold  <= i_cfg_data;
                qem_pkg::REG_SPEED_WIN:   r_cfg.speed_win   <= i_cfg_data;
                qem_pkg::REG_IDLE_TMO:    r_cfg.idle_tmo    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[src/qem_tracker.sv]
// qem_tracker: encoder state registers and the single-pass update for one
// edge or poll item. Depends on qem_pkg (t_item, t_cfg, t_result, tables).

module qem_tracker #(
    parameter int POSITION_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  qem_pkg::t_cfg    i_cfg,
    input  logic             i_step_en,
    input  qem_pkg::t_item   i_item,
    output qem_pkg::t_result o_result
);

    localparam int PW = POSITION_WIDTH;

    // State
    logic [PW-1:0]                    r_pos,  n_pos;
    qem_pkg::t_dir                    r_dir,  n_dir;
    logic [1:0]                       r_last_ab, n_last_ab;
    logic [qem_pkg::TIME_W-1:0]       r_last_step_time, n_last_step_time;
    logic [qem_pkg::TIME_W-1:0]       r_win_time, n_win_time;
    logic [PW-1:0]                    r_win_pos, n_win_pos;
    logic [qem_pkg::CNT_W-1:0]        r_speed, n_speed;
    logic [qem_pkg::CNT_W-1:0]        r_err, n_err;
    logic                             r_r_present, n_r_present;
    logic [qem_pkg::TIME_W-1:0]       r_last_r_high, n_last_r_high;
    logic                             r_last_r_level, n_last_r_level;
    logic                             r_idx_active, n_idx_active;
    qem_pkg::t_dir                    r_idx_dir, n_idx_dir;
    logic [PW-1:0]                    r_idx_ref, n_idx_ref;
    logic [qem_pkg::CNT_W-1:0]        r_idx_count, n_idx_count;
    logic [qem_pkg::SEEN_W-1:0]       r_seen, n_seen;

    // Edge decode
    qem_pkg::t_dir step;
    assign step = qem_pkg::STEP_TABLE[{r_last_ab, i_item.level_a, i_item.level_b}];

    // Distance from the window start and from the index reference
    logic [PW-1:0] win_diff, win_mag, idx_diff, idx_mag;
    logic          win_sat;
    assign win_diff = r_pos - r_win_pos;
    assign win_mag  = win_diff[PW-1] ? (~win_diff + PW'(1)) : win_diff;
    assign idx_diff = r_pos - r_idx_ref;
    assign idx_mag  = idx_diff[PW-1] ? (~idx_diff + PW'(1)) : idx_diff;

    // Speed saturates only when the position is wider than the output
    generate
        if (PW > qem_pkg::CNT_W) begin : g_sat
            assign win_sat = |win_mag[PW-1:qem_pkg::CNT_W];
        end else begin : g_nosat
            assign win_sat = 1'b0;
        end
    endgenerate

    // Elapsed times (modulo 2^32)
    logic [qem_pkg::TIME_W-1:0] dt_r_high, dt_win, dt_step;
    assign dt_r_high = i_item.now_ms - r_last_r_high;
    assign dt_win    = i_item.now_ms - r_win_time;
    assign dt_step   = i_item.now_ms - r_last_step_time;

    // Differential flags of this item
    logic [1:0] dflag_a, dflag_b, dflag_r;
    assign dflag_a = qem_pkg::diff_check(i_item.a_plus, i_item.a_minus, i_cfg.diff_thresh);
    assign dflag_b = qem_pkg::diff_check(i_item.b_plus, i_item.b_minus, i_cfg.diff_thresh);
    assign dflag_r = qem_pkg::diff_check(i_item.r_plus, i_item.r_minus, i_cfg.diff_thresh);

    logic rising, abort;
    assign rising = i_item.level_r && !r_last_r_level;
    // Direction checked against the one latched now or at the last rising edge
    assign abort  = (rising || r_idx_active) && (r_dir != qem_pkg::DIR_ZERO)
                    && (r_dir != (rising ? r_dir : r_idx_dir));

    // Next state
    always_comb begin
        n_pos            = r_pos;
        n_dir            = r_dir;
        n_last_ab        = r_last_ab;
        n_last_step_time = r_last_step_time;
        n_win_time       = r_win_time;
        n_win_pos        = r_win_pos;
        n_speed          = r_speed;
        n_err            = r_err;
        n_r_present      = r_r_present;
        n_last_r_high    = r_last_r_high;
        n_last_r_level   = r_last_r_level;
        n_idx_active     = r_idx_active;
        n_idx_dir        = r_idx_dir;
        n_idx_ref        = r_idx_ref;
        n_idx_count      = r_idx_count;
        n_seen           = r_seen;
        case (i_item.opcode)
            qem_pkg::OP_EDGE: begin
                // step decode and position
                if (step != qem_pkg::DIR_ZERO) begin
                    n_pos            = (step == qem_pkg::DIR_POS) ? r_pos + PW'(1)
                                                                  : r_pos - PW'(1);
                    n_dir            = step;
                    n_last_step_time = i_item.now_ms;
                    n_last_ab        = {i_item.level_a, i_item.level_b};
                    n_seen[0]        = r_seen[0] | i_item.level_a;
                    n_seen[1]        = r_seen[1] | i_item.level_b;
                end else begin
                    n_err = r_err + qem_pkg::CNT_W'(1);
                end
                // sticky ADC flags
                if (i_cfg.diff_mode) begin
                    n_seen[7:2] = r_seen[7:2] | {dflag_r, dflag_b, dflag_a};
                end
            end
            qem_pkg::OP_POLL: begin
                // index presence with hold time
                if (i_item.level_r) begin
                    n_r_present   = 1'b1;
                    n_last_r_high = i_item.now_ms;
                end else if (dt_r_high > qem_pkg::TIME_W'(i_cfg.index_hold)) begin
                    n_r_present = 1'b0;
                end
                n_last_r_level = i_item.level_r;
                // speed window
                if (dt_win >= qem_pkg::TIME_W'(i_cfg.speed_win)) begin
                    n_speed    = win_sat ? '1 : qem_pkg::CNT_W'(win_mag);
                    n_win_pos  = r_pos;
                    n_win_time = i_item.now_ms;
                end
                // index pulse counting
                if (rising) begin
                    n_idx_active = 1'b1;
                    n_idx_dir    = r_dir;
                    n_idx_ref    = r_pos;
                    n_idx_count  = '0;
                end
                if (abort) begin
                    n_idx_active = 1'b0;
                    n_idx_count  = '0;
                end else if (rising) begin
                    n_idx_ref = r_pos;
                end else if (r_idx_active) begin
                    n_idx_count = r_idx_count + qem_pkg::CNT_W'(idx_mag);
                    n_idx_ref   = r_pos;
                end
                // idle timeout clears direction
                if (dt_step > qem_pkg::TIME_W'(i_cfg.idle_tmo)) begin
                    n_dir = qem_pkg::DIR_ZERO;
                end
            end
            default: ;
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos            <= '0;
            r_dir            <= qem_pkg::DIR_ZERO;
            r_last_ab        <= '0;
            r_last_step_time <= '0;
            r_win_time       <= '0;
            r_win_pos        <= '0;
            r_speed          <= '0;
            r_err            <= '0;
            r_r_present      <= 1'b0;
            r_last_r_high    <= '0;
            r_last_r_level   <= 1'b0;
            r_idx_active     <= 1'b0;
            r_idx_dir        <= qem_pkg::DIR_ZERO;
            r_idx_ref        <= '0;
            r_idx_count      <= '0;
            r_seen           <= '0;
        end else if (i_step_en) begin
            r_pos            <= n_pos;
            r_dir            <= n_dir;
            r_last_ab        <= n_last_ab;
            r_last_step_time <= n_last_step_time;
            r_win_time       <= n_win_time;
            r_win_pos        <= n_win_pos;
            r_speed          <= n_speed;
            r_err            <= n_err;
            r_r_present      <= n_r_present;
            r_last_r_high    <= n_last_r_high;
            r_last_r_level   <= n_last_r_level;
            r_idx_active     <= n_idx_active;
            r_idx_dir        <= n_idx_dir;
            r_idx_ref        <= n_idx_ref;
            r_idx_count      <= n_idx_count;
            r_seen           <= n_seen;
        end
    end

    // Result reflects the state after this item
    assign o_result.position          = qem_pkg::CNT_W'(n_pos);
    assign o_result.direction         = n_dir;
    assign o_result.speed             = n_speed;
    assign o_result.error_count       = n_err;
    assign o_result.index_present     = n_r_present;
    assign o_result.index_pulse_count = n_idx_count;
    assign o_result.in_index_cycle    = n_idx_active;
    assign o_result.a_seen_high       = n_seen[0];
    assign o_result.b_seen_high       = n_seen[1];
    assign o_result.diff_flags        = n_seen[7:2];

endmodule

[src/quadrature_encoder_monitor.sv]
// quadrature_encoder_monitor: top level with input register, result register
// and stream ports. Depends on qem_pkg, qem_cfg_regs and qem_tracker.

// Takes one item per clock while the result stream is not stalled: an edge
// item (A/B levels plus six ADC readings) or a poll item (R level and time),
// and returns one result per item with the encoder state after it. An item is
// registered at the input and the whole state update runs in one pass into
// the result register, which keeps the rate at one item per clock. While a
// result waits, the input register still takes one more item; after that the
// input stalls until the result is taken.
// Configuration writes are accepted every cycle; write only while idle.

module quadrature_encoder_monitor #(
    parameter int POSITION_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [0] level_a, [1] level_b, [2] level_r, [34:3] now_ms, [44:35] a_plus,
    // [54:45] a_minus, [64:55] b_plus, [74:65] b_minus, [84:75] r_plus,
    // [94:85] r_minus, [95] zero
    input  logic [qem_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [0] opcode
    input  logic [qem_pkg::IN_TUSER_W-1:0]  i_s_axis_tuser,
    // result stream
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [31:0] position, [33:32] direction, [65:34] speed, [97:66] error_count,
    // [98] index_present, [130:99] index_pulse_count, [131] in_index_cycle,
    // [132] a_seen_high, [133] b_seen_high, [139:134] diff_flags, [143:140] zero
    output logic [qem_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [qem_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [qem_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    qem_pkg::t_cfg    cfg;
    qem_pkg::t_item   in_item;
    qem_pkg::t_result result;

    logic             r_in_valid;
    qem_pkg::t_item   r_in_item;
    logic             r_out_valid;
    logic [qem_pkg::OUT_TDATA_W-1:0] r_out_tdata;
    logic             advance;

    assign o_cfg_ready = 1'b1;

    qem_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Unpack the stream payload
    assign in_item.opcode  = qem_pkg::t_opcode'(i_s_axis_tuser[0]);
    assign in_item.level_a = i_s_axis_tdata[0];
    assign in_item.level_b = i_s_axis_tdata[1];
    assign in_item.level_r = i_s_axis_tdata[2];
    assign in_item.now_ms  = i_s_axis_tdata[34:3];
    assign in_item.a_plus  = i_s_axis_tdata[44:35];
    assign in_item.a_minus = i_s_axis_tdata[54:45];
    assign in_item.b_plus  = i_s_axis_tdata[64:55];
    assign in_item.b_minus = i_s_axis_tdata[74:65];
    assign in_item.r_plus  = i_s_axis_tdata[84:75];
    assign in_item.r_minus = i_s_axis_tdata[94:85];

    // Handshake: an item moves on when the result register is free or drains
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_item <= in_item;
        end
    end

    qem_tracker #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_tracker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_step_en (advance),
        .i_item    (r_in_item),
        .o_result  (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_tdata <= {4'b0000,
                            result.diff_flags,
                            result.b_seen_high,
                            result.a_seen_high,
                            result.in_index_cycle,
                            result.index_pulse_count,
                            result.index_present,
                            result.error_count,
                            result.speed,
                            result.direction,
                            result.position};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_tdata;

endmodule
